>>> src/constant_curvature_arc_endpoint_assert.svh
// Assertion macros for the constant-curvature arc endpoint block.
`ifndef CONSTANT_CURVATURE_ARC_ENDPOINT_ASSERT_SVH
`define CONSTANT_CURVATURE_ARC_ENDPOINT_ASSERT_SVH

// Implication checked in the following cycle.
`define CCAE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pipeline assertion failed");

// Implication checked in the same cycle.
`define CCAE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pipeline assertion failed");

`endif

>>> src/ccae_pkg.sv
// Package with beat types, constants and the CORDIC angle table of the arc endpoint block.
package ccae_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int DIV_BITS = 34;
    localparam int DEN_W = 24;

    localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
    localparam logic [55:0] SMALL_P = 56'd17179869;
    localparam logic [15:0] RECIP_SIX = 16'd43691;
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [15:0]        start_heading;
        logic signed [23:0] curvature;
        logic [31:0]        arc_length;
    } arc_t;

    typedef struct packed {
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [15:0]        end_heading;
    } result_t;

    function automatic logic [29:0] turn_atan(input logic [4:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            5'd30: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/ccae_cordic.sv
// Pipelined rotation-mode CORDIC giving clamped Q30 cosine and sine of a turn angle.
module ccae_cordic
    import ccae_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        ang,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);

    logic signed [32:0] x_reg [0:CORDIC_N];
    logic signed [32:0] y_reg [0:CORDIC_N];
    logic signed [33:0] z_reg [0:CORDIC_N];
    logic               flip_reg [0:CORDIC_N];

    logic [31:0]        ang_rot;
    logic               flip;
    logic [31:0]        ang_fold;
    logic signed [32:0] x_out;
    logic signed [32:0] y_out;

    assign ang_rot  = ang + 32'h4000_0000;
    assign flip     = ang_rot[31];
    assign ang_fold = flip ? ang + 32'h8000_0000 : ang;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_X0;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({{2{ang_fold[31]}}, ang_fold});
            flip_reg[0] <= flip;
        end
    end

    for (genvar i = 1; i <= CORDIC_N; i++)
    begin : g_iter
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        logic signed [33:0] at;

        assign xs = x_reg[i-1] >>> (i - 1);
        assign ys = y_reg[i-1] >>> (i - 1);
        assign at = $signed({4'b0000, turn_atan(5'(i - 1))});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i-1] >= 0)
                begin
                    x_reg[i] <= x_reg[i-1] - ys;
                    y_reg[i] <= y_reg[i-1] + xs;
                    z_reg[i] <= z_reg[i-1] - at;
                end
                else
                begin
                    x_reg[i] <= x_reg[i-1] + ys;
                    y_reg[i] <= y_reg[i-1] - xs;
                    z_reg[i] <= z_reg[i-1] + at;
                end
                flip_reg[i] <= flip_reg[i-1];
            end
        end
    end

    assign x_out = flip_reg[CORDIC_N] ? -x_reg[CORDIC_N] : x_reg[CORDIC_N];
    assign y_out = flip_reg[CORDIC_N] ? -y_reg[CORDIC_N] : y_reg[CORDIC_N];

    always_comb
    begin
        if (x_out > 33'sd1073741824)
            cos_q30 = 32'sd1073741824;
        else if (x_out < -33'sd1073741824)
            cos_q30 = -32'sd1073741824;
        else
            cos_q30 = x_out[31:0];

        if (y_out > 33'sd1073741824)
            sin_q30 = 32'sd1073741824;
        else if (y_out < -33'sd1073741824)
            sin_q30 = -32'sd1073741824;
        else
            sin_q30 = y_out[31:0];
    end

endmodule

>>> src/ccae_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
module ccae_div
    import ccae_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [DIV_BITS-1:0] num,
    input  logic [DEN_W-1:0]    den,
    output logic [DIV_BITS-1:0] quo
);

    logic [DEN_W-1:0]    rem_reg [0:DIV_BITS-1];
    logic [DIV_BITS-1:0] nq_reg  [0:DIV_BITS-1];
    logic [DEN_W-1:0]    den_reg [0:DIV_BITS-1];

    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_step
        logic [DEN_W-1:0]    rem_prev;
        logic [DIV_BITS-1:0] nq_prev;
        logic [DEN_W-1:0]    den_prev;
        logic [DEN_W:0]      trial;
        logic [DEN_W:0]      diff;
        logic                ge;

        if (j == 0)
        begin : g_first
            assign rem_prev = '0;
            assign nq_prev  = num;
            assign den_prev = den;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[j-1];
            assign nq_prev  = nq_reg[j-1];
            assign den_prev = den_reg[j-1];
        end

        assign trial = {rem_prev, nq_prev[DIV_BITS-1]};
        assign diff  = trial - {1'b0, den_prev};
        assign ge    = trial >= {1'b0, den_prev};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                nq_reg[j]  <= {nq_prev[DIV_BITS-2:0], ge};
                den_reg[j] <= den_prev;
            end
        end
    end

    assign quo = nq_reg[DIV_BITS-1];

endmodule

>>> src/constant_curvature_arc_endpoint.sv
// Top level of the constant-curvature arc endpoint pipeline.
//
// The arc channel (arc_valid, arc_ready, arc) takes one start pose with curvature
// and arc length per beat. The result channel (result_valid, result_ready, result)
// returns the end pose of that arc, one beat per input beat, in input order.
// From acceptance to result_valid, a beat passes through the curvature product,
// the half-angle CORDIC, the 34-stage chord divider and the final multiply and
// round stages.
// Throughput is one beat per cycle: a new arc enters every cycle while the result
// register is empty or is being taken.
// When the receiver holds result_ready low with a result waiting, the whole pipeline
// freezes and arc_ready drops; no beat is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready after reset.
module constant_curvature_arc_endpoint
    import ccae_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    arc_valid,
    output logic    arc_ready,
    input  arc_t    arc,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int LC   = CORDIC_N + 1;
    localparam int AB   = 2 + DIV_BITS;
    localparam int TD   = LC + 2 + DIV_BITS;
    localparam int LAST = TD + 1;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic [15:0]        hd;
        logic               series;
        logic signed [23:0] k;
        logic [31:0]        len;
        logic [31:0]        half;
        logic [31:0]        angb;
        logic [15:0]        a2;
        logic signed [32:0] dser;
        logic               qneg;
    } side_t;

    logic en;

    logic               s1_vld_reg;
    arc_t               s1_in_reg;
    logic signed [56:0] s1_p_reg;

    logic               s2_vld_reg;
    arc_t               s2_in_reg;
    logic               s2_neg_reg;
    logic               s2_series_reg;
    logic [53:0]        s2_hi_reg;
    logic [29:0]        s2_lo_reg;
    logic [15:0]        s2_a2_reg;

    logic [56:0]        s2_mag_full;
    logic [55:0]        s2_mag;
    logic [61:0]        s2_lo_full;
    logic [49:0]        s2_sq;

    logic [54:0]        s3_tm;
    logic [32:0]        s3_tu;
    logic [31:0]        s3_heading_sum;
    side_t              s3_side;

    logic [LAST:0]      vld_reg;
    side_t              sd_reg [0:LAST];
    side_t              sd_next [1:LAST];

    logic [31:0]        ser_q1_reg;
    logic [45:0]        ser_lq_reg;
    logic signed [32:0] dser_next;

    logic signed [31:0] ca_cos;
    logic signed [31:0] ca_sin;
    logic signed [34:0] sin_x8;
    logic [33:0]        sin_mag;
    logic [23:0]        k_mag;
    logic [DIV_BITS-1:0] dv_num_reg;
    logic [DEN_W-1:0]   dv_den_reg;
    logic [DIV_BITS-1:0] dv_quo;
    logic [32:0]        q_clamp;
    logic signed [32:0] d_next;
    logic signed [32:0] d_reg;

    logic signed [31:0] cb_cos;
    logic signed [31:0] cb_sin;
    logic signed [64:0] mx_reg;
    logic signed [64:0] my_reg;
    logic signed [64:0] rx;
    logic signed [64:0] ry;
    logic signed [35:0] sum_x;
    logic signed [35:0] sum_y;
    logic signed [31:0] sat_x;
    logic signed [31:0] sat_y;

    logic               out_vld_reg;
    result_t            out_reg;

    assign en        = !out_vld_reg || result_ready;
    assign arc_ready = en;

    // Stage 1: exact curvature times length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= arc_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_in_reg <= arc;
            s1_p_reg  <= $signed(arc.curvature) * $signed({1'b0, arc.arc_length});
        end
    end

    // Stage 2: magnitude, turn conversion partial products and the series square.
    assign s2_mag_full = s1_p_reg[56] ? 57'(-s1_p_reg) : s1_p_reg;
    assign s2_mag      = s2_mag_full[55:0];
    assign s2_lo_full  = s2_mag[31:0] * INV_2PI_Q32;
    assign s2_sq       = s2_mag[24:0] * s2_mag[24:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_in_reg     <= s1_in_reg;
            s2_neg_reg    <= s1_p_reg[56];
            s2_series_reg <= s2_mag <= SMALL_P;
            s2_hi_reg     <= s2_mag[55:32] * INV_2PI_Q32;
            s2_lo_reg     <= s2_lo_full[61:32];
            s2_a2_reg     <= s2_sq[49:34];
        end
    end

    // Stage 3: signed turn angle, heading change and half angle.
    assign s3_tm          = {1'b0, s2_hi_reg} + {25'b0, s2_lo_reg};
    assign s3_tu          = s2_neg_reg ? 33'(-s3_tm[32:0]) : s3_tm[32:0];
    assign s3_heading_sum = {s2_in_reg.start_heading, 16'h0000} + s3_tu[31:0] + 32'h0000_8000;

    always_comb
    begin
        s3_side        = '0;
        s3_side.sx     = s2_in_reg.start_x;
        s3_side.sy     = s2_in_reg.start_y;
        s3_side.hd     = s3_heading_sum[31:16];
        s3_side.series = s2_series_reg;
        s3_side.k      = s2_in_reg.curvature;
        s3_side.len    = s2_in_reg.arc_length;
        s3_side.half   = s3_tu[32:1];
        s3_side.angb   = {s2_in_reg.start_heading, 16'h0000} + s3_tu[32:1];
        s3_side.a2     = s2_a2_reg;
    end

    // Series chord length: len * (1 - a2/6); the fourth-order term is below one lsb
    // over the whole small-angle range.
    assign dser_next = $signed({1'b0, sd_reg[2].len}) - $signed({19'b0, ser_lq_reg[45:32]})
                       - $signed({32'b0, |ser_lq_reg[31:0]});

    assign sin_x8  = {ca_sin, 3'b000};
    assign sin_mag = ca_sin[31] ? 34'(-sin_x8) : sin_x8[33:0];
    assign k_mag   = sd_reg[LC].k[23] ? 24'(-sd_reg[LC].k) : sd_reg[LC].k;

    assign q_clamp = (dv_quo > 34'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF : {1'b0, dv_quo[31:0]};

    always_comb
    begin
        if (sd_reg[TD-1].series)
            d_next = sd_reg[TD-1].dser;
        else if (sd_reg[TD-1].qneg)
            d_next = -$signed(q_clamp);
        else
            d_next = $signed(q_clamp);
    end

    always_comb
    begin
        for (int i = 1; i <= LAST; i++)
            sd_next[i] = sd_reg[i-1];
        sd_next[3].dser    = dser_next;
        sd_next[LC+1].qneg = ca_sin[31] ^ sd_reg[LC].k[23];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAST-1:0], s2_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= s3_side;
            for (int i = 1; i <= LAST; i++)
                sd_reg[i] <= sd_next[i];

            ser_q1_reg <= sd_reg[0].a2 * RECIP_SIX;
            ser_lq_reg <= sd_reg[1].len * ser_q1_reg[31:18];

            dv_num_reg <= sin_mag;
            dv_den_reg <= k_mag;
            d_reg      <= d_next;

            mx_reg <= d_reg * cb_cos;
            my_reg <= d_reg * cb_sin;
        end
    end

    ccae_cordic u_cordic_half
    (
        .clk     (clk),
        .en      (en),
        .ang     (sd_reg[0].half),
        .cos_q30 (ca_cos),
        .sin_q30 (ca_sin)
    );

    ccae_div u_div
    (
        .clk (clk),
        .en  (en),
        .num (dv_num_reg),
        .den (dv_den_reg),
        .quo (dv_quo)
    );

    ccae_cordic u_cordic_dir
    (
        .clk     (clk),
        .en      (en),
        .ang     (sd_reg[AB].angb),
        .cos_q30 (cb_cos),
        .sin_q30 (cb_sin)
    );

    // Round, add the start point and saturate.
    assign rx    = (mx_reg + 65'sd536870912) >>> 30;
    assign ry    = (my_reg + 65'sd536870912) >>> 30;
    assign sum_x = $signed({{4{sd_reg[LAST].sx[31]}}, sd_reg[LAST].sx}) + $signed(rx[35:0]);
    assign sum_y = $signed({{4{sd_reg[LAST].sy[31]}}, sd_reg[LAST].sy}) + $signed(ry[35:0]);

    always_comb
    begin
        if (sum_x > 36'sd2147483647)
            sat_x = 32'sh7FFF_FFFF;
        else if (sum_x < -36'sd2147483648)
            sat_x = 32'sh8000_0000;
        else
            sat_x = sum_x[31:0];

        if (sum_y > 36'sd2147483647)
            sat_y = 32'sh7FFF_FFFF;
        else if (sum_y < -36'sd2147483648)
            sat_y = 32'sh8000_0000;
        else
            sat_y = sum_y[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.end_x       <= sat_x;
            out_reg.end_y       <= sat_y;
            out_reg.end_heading <= sd_reg[LAST].hd;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    `include "constant_curvature_arc_endpoint_assert.svh"

    `CCAE_ASSERT_NEXT(a_last_to_out, en && vld_reg[LAST], result_valid)
    `CCAE_ASSERT_NEXT(a_freeze_holds, !en, $stable(vld_reg) && $stable(s2_vld_reg))
    `CCAE_ASSERT_SAME(a_stall_cause, !arc_ready, result_valid && !result_ready)

endmodule

>>> test/tb_constant_curvature_arc_endpoint.sv
// Testbench for the constant-curvature arc endpoint block with a bit-exact arc predictor.
`timescale 1ns / 100ps

module tb_constant_curvature_arc_endpoint;
    import ccae_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_PER_PHASE = 150;
    localparam longint SMALL_ANGLE = 17179869;
    localparam longint INV_TWO_PI = 683565276;
    localparam longint GAIN_START = 652032874;
    localparam longint UNIT_Q30 = 1073741824;

    typedef struct {
        arc_t    arc;
        bit      typed;
        result_t pose;
    } row_t;

    localparam longint ATAN_TURN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    logic    clk;
    logic    rst_n;
    logic    arc_valid;
    logic    arc_ready;
    arc_t    arc;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    result_t end_pose_q[$];
    int      errors;
    int      idle_cycles;
    int      send_gap_pct;
    int      recv_stall_pct;

    constant_curvature_arc_endpoint i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .arc_valid    (arc_valid),
        .arc_ready    (arc_ready),
        .arc          (arc),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        int     n;
        x = GAIN_START;
        y = 0;
        n = CORDIC_STAGES > 32 ? 32 : CORDIC_STAGES;
        flip = ((ang + 32'h4000_0000) & 32'h8000_0000) != 0;
        if (flip)
        begin
            ang = ang + 32'h8000_0000;
        end
        z = longint'(signed'(ang));
        for (int i = 0; i < n; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURN[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURN[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clamp(x, -UNIT_Q30, UNIT_Q30);
        s = clamp(y, -UNIT_Q30, UNIT_Q30);
    endfunction

    function automatic result_t arc_endpoint(arc_t a);
        longint      k;
        longint      len;
        longint      p;
        longint      mag;
        longint      d;
        longint      c;
        longint      s;
        longint      x;
        longint      y;
        logic [63:0] tm;
        logic [63:0] tu;
        logic [63:0] a2;
        logic [63:0] a4;
        logic [63:0] f;
        logic [63:0] lf;
        logic [31:0] half;
        logic [31:0] hq;
        logic [32:0] hsum;
        result_t     r;
        k = longint'(a.curvature);
        len = longint'(a.arc_length);
        p = k * len;
        mag = p < 0 ? -p : p;
        tm = ((mag >> 32) * INV_TWO_PI) + (((mag & 64'hFFFF_FFFF) * INV_TWO_PI) >> 32);
        tu = p < 0 ? 64'd0 - tm : tm;
        half = tu[32:1];
        hq = {a.start_heading, 16'h0000};
        if (mag <= SMALL_ANGLE)
        begin
            a2 = (mag * mag) >> 34;
            a4 = (a2 * a2) >> 32;
            f = 64'h1_0000_0000 - a2 / 6 + a4 / 120;
            lf = 64'(len) * f;
            d = longint'(lf >> 32);
        end
        else
        begin
            rotate(half, c, s);
            d = (s * 8) / k;
        end
        d = clamp(d, -64'sh0_FFFF_FFFF, 64'sh0_FFFF_FFFF);
        rotate(hq + half, c, s);
        x = longint'(a.start_x) + ((d * c + UNIT_Q30 / 2) >>> 30);
        y = longint'(a.start_y) + ((d * s + UNIT_Q30 / 2) >>> 30);
        r.end_x = 32'(clamp(x, -64'sh8000_0000, 64'sh7FFF_FFFF));
        r.end_y = 32'(clamp(y, -64'sh8000_0000, 64'sh7FFF_FFFF));
        hsum = {1'b0, hq + tu[31:0]} + 33'h8000;
        r.end_heading = hsum[31:16];
        return r;
    endfunction

    function automatic arc_t random_arc();
        arc_t a;
        int   mode;
        a.start_x = $urandom;
        a.start_y = $urandom;
        a.start_heading = 16'($urandom);
        mode = $urandom_range(0, 9);
        if (mode < 3)
        begin
            a.curvature = 24'($urandom_range(0, 512) - 256);
            a.arc_length = $urandom_range(0, 32'h00FF_FFFF);
        end
        else if (mode < 6)
        begin
            a.curvature = 24'($urandom);
            a.arc_length = $urandom;
        end
        else if (mode < 8)
        begin
            a.curvature = 24'($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            a.arc_length = $urandom_range(0, 32'h0040_0000);
        end
        else
        begin
            a.curvature = $urandom_range(0, 1) ? 24'sh00_0000 : 24'(signed'($urandom_range(0, 3)) - 1);
            a.arc_length = $urandom;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            a.start_x = $urandom_range(0, 1) ? 32'sh7FFF_F000 + $urandom_range(0, 4095)
                                            : 32'sh8000_0000 + $urandom_range(0, 4095);
        end
        return a;
    endfunction

    task automatic send_arc(arc_t a, bit typed, result_t pose);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            arc_valid <= 1'b0;
            @(posedge clk);
        end
        arc_valid <= 1'b1;
        arc <= a;
        @(posedge clk);
        while (!arc_ready)
        begin
            @(posedge clk);
        end
        end_pose_q.push_back(typed ? pose : arc_endpoint(a));
    endtask

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && result_valid && result_ready)
        begin
            if (end_pose_q.size() == 0)
            begin
                $error("result beat with no expected pose");
                errors++;
            end
            else
            begin
                if (result.end_x !== end_pose_q[0].end_x)
                begin
                    $error("end_x expected %0d actual %0d", end_pose_q[0].end_x, result.end_x);
                    errors++;
                end
                if (result.end_y !== end_pose_q[0].end_y)
                begin
                    $error("end_y expected %0d actual %0d", end_pose_q[0].end_y, result.end_y);
                    errors++;
                end
                if (result.end_heading !== end_pose_q[0].end_heading)
                begin
                    $error("end_heading expected %0d actual %0d",
                           end_pose_q[0].end_heading, result.end_heading);
                    errors++;
                end
                void'(end_pose_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (arc_valid && arc_ready) || (result_valid && result_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        row_t directed [16];
        directed = '{
            '{'{32'sh0, 32'sh0, 16'h0000, 24'sh0, 32'h0}, 1'b1, '{32'sh0, 32'sh0, 16'h0000}},
            '{'{32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 24'sh7F_FFFF, 32'h0}, 1'b1,
              '{32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF}},
            '{'{32'sh0, 32'sh0, 16'h0000, 24'sh0, 32'h0001_0000}, 1'b0, '{0, 0, 0}},
            '{'{32'sh7FFF_FFFF, 32'sh0, 16'h0000, 24'sh0, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{32'sh8000_0000, 32'sh0, 16'h8000, 24'sh0, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{32'sh0, 32'sh7FFF_FFFF, 16'h4000, 24'sh0, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{32'sh0, 32'sh8000_0000, 16'hC000, 24'sh0, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{32'sh100, 32'sh200, 16'h1234, 24'sh1, 32'd17179869}, 1'b0, '{0, 0, 0}},
            '{'{32'sh100, 32'sh200, 16'h1234, 24'sh1, 32'd17179870}, 1'b0, '{0, 0, 0}},
            '{'{32'sh100, 32'sh200, 16'h1234, -24'sh1, 32'd17179870}, 1'b0, '{0, 0, 0}},
            '{'{32'sh0, 32'sh0, 16'h2000, 24'sh7F_FFFF, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{32'sh0, 32'sh0, 16'h2000, 24'sh80_0000, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0}},
            '{'{32'sh1_0000, -32'sh1_0000, 16'h0000, 24'sh01_0000, 32'h0003_0000}, 1'b0, '{0, 0, 0}},
            '{'{32'sh0, 32'sh0, 16'h0000, -24'sh01_0000, 32'h0002_0000}, 1'b0, '{0, 0, 0}},
            '{'{32'sh5555_5555, 32'shAAAA_AAAA, 16'h0000, 24'sh80_0000, 32'h1}, 1'b0, '{0, 0, 0}},
            '{'{32'sh0, 32'sh0, 16'hFFFF, 24'sh00_4000, 32'h0010_0000}, 1'b0, '{0, 0, 0}}
        };
        clk = 1'b0;
        rst_n = 1'b0;
        arc_valid = 1'b0;
        arc = '0;
        result_ready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            send_arc(directed[i].arc, directed[i].typed, directed[i].pose);
        end
        for (int phase = 0; phase < 4; phase++)
        begin
            send_gap_pct = (phase == 1) ? 45 : (phase == 3) ? 29 : 0;
            recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 29 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                send_arc(random_arc(), 1'b0, '0);
            end
        end
        arc_valid <= 1'b0;
        while (end_pose_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
